// ----- src/wal_pkg.sv -----
// ----------------------------------------------------------------------------
// wal_pkg: shared types and constants of the windowed average level meter
// Control word layout, sequencer status, field widths and the bar-graph bands.
// ----------------------------------------------------------------------------
`default_nettype none

package wal_pkg;

  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 12;
  localparam int LEVEL_W  = 4;
  localparam int CNT_W    = 4;   // counts quotient bits AVG_W-1 .. 0
  localparam int NUM_CH   = 2;
  localparam int BAR_W    = 10;  // average / 4
  localparam int NUM_EDGE = 10;

  // Upper edge of each bar-graph band; level = number of edges below v.
  localparam logic [BAR_W-1:0] LEVEL_EDGE [NUM_EDGE] = '{
    10'd50, 10'd150, 10'd207, 10'd309, 10'd411,
    10'd513, 10'd650, 10'd700, 10'd800, 10'd900
  };

  localparam int STEP_W = 2;
  typedef logic [STEP_W-1:0] wal_step_t;

  localparam wal_step_t STEP_TAKE   = 2'd0;
  localparam wal_step_t STEP_UPDATE = 2'd1;
  localparam wal_step_t STEP_DIV    = 2'd2;
  localparam wal_step_t STEP_EMIT   = 2'd3;

  typedef enum logic [1:0] {
    OP_TAKE,
    OP_UPDATE,
    OP_DIV,
    OP_EMIT
  } wal_op_t;

  typedef enum logic [1:0] {
    CND_NONE,
    CND_IN_IDLE,
    CND_BITS_LEFT,
    CND_OUT_BUSY
  } wal_cond_t;

  typedef struct packed {
    wal_op_t   op;
    wal_cond_t cond;
    wal_step_t target;
  } wal_ctrl_t;

  typedef struct packed {
    logic in_idle;
    logic bits_left;
    logic out_busy;
  } wal_status_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [BAR_W-1:0] v);
    logic [LEVEL_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_EDGE; i++) begin
      if (v > LEVEL_EDGE[i]) n = n + LEVEL_W'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/wal_sequencer.sv -----
// ----------------------------------------------------------------------------
// wal_sequencer: step counter and control store
// Fetch one control word per step; jump to its target when its condition holds.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_sequencer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wal_pkg::wal_status_t status,
  output wal_pkg::wal_ctrl_t       ctrl
);
  import wal_pkg::*;

  // Fall-through is step + 1 (wraps from the last step to the first).
  localparam wal_ctrl_t PROG [4] = '{
    '{op: OP_TAKE,   cond: CND_IN_IDLE,   target: STEP_TAKE},
    '{op: OP_UPDATE, cond: CND_NONE,      target: STEP_DIV},
    '{op: OP_DIV,    cond: CND_BITS_LEFT, target: STEP_DIV},
    '{op: OP_EMIT,   cond: CND_OUT_BUSY,  target: STEP_EMIT}
  };

  wal_step_t pc_r, pc_nxt;
  logic      jump;

  assign ctrl = PROG[pc_r];

  always_comb begin
    unique case (ctrl.cond)
      CND_NONE:      jump = 1'b0;
      CND_IN_IDLE:   jump = status.in_idle;
      CND_BITS_LEFT: jump = status.bits_left;
      CND_OUT_BUSY:  jump = status.out_busy;
      default:       jump = 1'b0;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_TAKE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/wal_datapath.sv -----
// ----------------------------------------------------------------------------
// wal_datapath: sample rings, running sums and restoring divider
// Update a channel's ring and sum, then divide by the fill count a bit a step.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_datapath #(
  parameter int WINDOW = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire wal_pkg::wal_ctrl_t            ctrl,
  input  wire logic                          take,
  input  wire logic                          in_channel,
  input  wire logic [wal_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               bits_left,
  output logic [wal_pkg::AVG_W-1:0]          average,
  output logic [wal_pkg::LEVEL_W-1:0]        led_level
);
  import wal_pkg::*;

  localparam int DEPTH  = NUM_CH * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic                ch_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [ADDR_W-1:0]   addr_r;

  logic [SUM_W-1:0]  sum_r  [NUM_CH];
  logic [FILL_W-1:0] fill_r [NUM_CH];
  logic [POS_W-1:0]  pos_r  [NUM_CH];

  logic [SUM_W-1:0] rem_r, dsh_r;
  logic [AVG_W-1:0] quot_r;
  logic [CNT_W-1:0] cnt_r;

  logic [ADDR_W-1:0]   rd_addr;
  logic                full;
  logic [SAMPLE_W-1:0] old_smp;
  logic [SUM_W-1:0]    sum_nxt;
  logic [FILL_W-1:0]   fill_nxt;
  logic [POS_W-1:0]    pos_nxt;
  logic                ge;

  assign rd_addr = ADDR_W'(pos_r[in_channel])
                 + (in_channel ? ADDR_W'(WINDOW) : ADDR_W'(0));

  // A slot beyond the fill count was never written; its old sample is taken as zero.
  assign full     = (fill_r[ch_r] == FILL_W'(WINDOW));
  assign old_smp  = full ? rd_data_r : '0;
  assign sum_nxt  = sum_r[ch_r] - SUM_W'(old_smp) + SUM_W'(smp_r);
  assign fill_nxt = full ? fill_r[ch_r] : fill_r[ch_r] + FILL_W'(1);
  assign pos_nxt  = (pos_r[ch_r] == POS_W'(WINDOW - 1)) ? '0
                  : pos_r[ch_r] + POS_W'(1);

  assign ge        = (rem_r >= dsh_r);
  assign bits_left = (cnt_r != '0);
  assign average   = quot_r;
  assign led_level = level_of(quot_r[AVG_W-1 -: BAR_W]);

  // Ring memory: read at the accept step, write back at the update step.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data_r <= mem[rd_addr];
    end
    if (ctrl.op == OP_UPDATE) begin
      mem[addr_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c]  <= '0;
        fill_r[c] <= '0;
        pos_r[c]  <= '0;
      end
      cnt_r <= '0;
    end else begin
      unique case (ctrl.op)
        OP_TAKE: begin
          if (take) begin
            ch_r   <= in_channel;
            smp_r  <= in_sample;
            addr_r <= rd_addr;
          end
        end
        OP_UPDATE: begin
          sum_r[ch_r]  <= sum_nxt;
          fill_r[ch_r] <= fill_nxt;
          pos_r[ch_r]  <= pos_nxt;
          rem_r        <= sum_nxt;
          dsh_r        <= SUM_W'(fill_nxt) << (AVG_W - 1);
          cnt_r        <= CNT_W'(AVG_W - 1);
        end
        OP_DIV: begin
          // One quotient bit per step; the quotient never exceeds AVG_W bits.
          if (ge) rem_r <= rem_r - dsh_r;
          dsh_r  <= dsh_r >> 1;
          quot_r <= {quot_r[AVG_W-2:0], ge};
          if (bits_left) cnt_r <= cnt_r - CNT_W'(1);
        end
        OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_W'(WINDOW)) && (fill_r[1] <= FILL_W'(WINDOW)))
    else $error("fill count beyond window");

  a_pos_tracks_fill0: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] != FILL_W'(WINDOW)) |-> (FILL_W'(pos_r[0]) == fill_r[0]))
    else $error("channel 0 write position out of step with fill count");

  a_pos_tracks_fill1: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[1] != FILL_W'(WINDOW)) |-> (FILL_W'(pos_r[1]) == fill_r[1]))
    else $error("channel 1 write position out of step with fill count");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> (cnt_r == '0))
    else $error("emit before divide finished");

endmodule

`default_nettype wire

// ----- src/windowed_average_led_level_meter_core.sv -----
// ----------------------------------------------------------------------------
// windowed_average_led_level_meter_core: two-channel moving average meter
// Average each channel's last WINDOW samples and decode a bar-graph level.
// ----------------------------------------------------------------------------
// Each input word carries a 12-bit sample and its channel (potentiometer or
// light sensor). The block writes it into that channel's ring of the last
// WINDOW samples and returns one word: the truncated mean of the ring (sum
// divided by the number of samples seen, up to WINDOW) and a bar-graph level
// 0..10 taken from mean/4. A sample passes these steps from accept to result:
// one accept step that reads the outgoing ring slot, one step that updates the
// running sum, twelve steps of the shared restoring divider (one quotient bit
// each), and one step that loads the output register. The block takes a new
// word only in its accept step, so it finishes one word before taking the next;
// a result waiting in the output register does not block the next accept, only
// the next load. Rings need no clearing pass after reset: slots past the fill
// count are taken as zero.
`default_nettype none

module windowed_average_led_level_meter_core #(
  parameter int WINDOW = 40
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] sample, [15:12] zero
  input  wire logic        in_tuser,   // [0] channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [11:0] average, [15:12] led_level
);
  import wal_pkg::*;

  wal_ctrl_t   ctrl;
  wal_status_t status;

  logic               bits_left;
  logic [AVG_W-1:0]   average;
  logic [LEVEL_W-1:0] led_level;

  logic               out_valid_r;
  logic [AVG_W-1:0]   out_avg_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               take;
  logic               load;

  // Accept only in the sequencer's accept step.
  assign in_tready = (ctrl.op == OP_TAKE);
  assign take      = in_tready && in_tvalid;

  // Hold the emit step while the previous result is still unread.
  assign status.in_idle   = !in_tvalid;
  assign status.bits_left = bits_left;
  assign status.out_busy  = out_valid_r && !out_tready;

  assign load = (ctrl.op == OP_EMIT) && !status.out_busy;

  wal_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  wal_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .take       (take),
    .in_channel (in_tuser),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .bits_left  (bits_left),
    .average    (average),
    .led_level  (led_level)
  );

  // Output register: load on emit, drop valid once the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_avg_r   <= average;
        out_level_r <= led_level;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_level_r, out_avg_r};

endmodule

`default_nettype wire
